/* hdl/dlda_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlda_pkg: shared types and constants of the diagonal LDA classifier
// Request and result layouts, function and status codes, register indexes.
// ----------------------------------------------------------------------------
package dlda_pkg;

	localparam int MAX_CLASSES_DEF  = 8;
	localparam int MAX_FEATURES_DEF = 4096;

	localparam int CFG_W = 13;

	// function codes of a request
	localparam logic [1:0] FUNC_LOAD     = 2'd0;
	localparam logic [1:0] FUNC_TRAIN    = 2'd1;
	localparam logic [1:0] FUNC_FINALIZE = 2'd2;
	localparam logic [1:0] FUNC_TEST     = 2'd3;

	// result kinds and status codes
	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_PREDICT = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FLAT  = 2'd2;

	// configuration register indexes
	localparam logic REG_CLASS_TOTAL   = 1'b0;
	localparam logic REG_FEATURE_TOTAL = 1'b1;

	localparam logic [3:0]  CLASS_TOTAL_RST   = 4'd2;
	localparam logic [12:0] FEATURE_TOTAL_RST = 13'd4096;

	localparam logic [47:0] U48_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]         func;
		logic [2:0]         class_label;
		logic [11:0]        feature_index;
		logic signed [31:0] sample_value;
		logic [15:0]        class_size;
		logic               last_feature;
	} dlda_req_t;

	typedef struct packed {
		logic       result_kind;
		logic [2:0] best_class;
		logic [1:0] status;
	} dlda_res_t;

	// divider command: start pulse and saturation limit select
	typedef struct packed {
		logic go;
		logic sat48;
	} dlda_div_ctl_t;

endpackage
`default_nettype wire

/* hdl/dlda_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlda_mul: shared 64 x 64 multiplier
// One 32 x 32 multiplier stepped over four partial products into a 128-bit sum.
// ----------------------------------------------------------------------------
module dlda_mul import dlda_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [63:0]  a,
	input  wire logic [63:0]  b,
	output logic              done,
	output logic [127:0]      prod
);

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0]   step_q;
	logic         run_q, done_q;
	logic [31:0]  a_sel, b_sel;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	// select the halves for this step and shift the partial product into place
	always_comb begin
		a_sel = step_q[1] ? a_q[63:32] : a_q[31:0];
		b_sel = step_q[0] ? b_q[63:32] : b_q[31:0];
		pp    = a_sel * b_sel;
		case (step_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	// accumulate one partial product a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				a_q    <= a;
				b_q    <= b;
				acc_q  <= '0;
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				acc_q  <= acc_q + pp_sh;
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

/* hdl/dlda_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlda_div: shared 128 / 64 divider
// Restoring division, one quotient bit a cycle, quotient saturated.
// ----------------------------------------------------------------------------
module dlda_div import dlda_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dlda_div_ctl_t ctl,
	input  wire logic [127:0]  num,
	input  wire logic [63:0]   den,
	output logic               done,
	output logic [63:0]        quot
);

	logic [127:0] n_q, q_q;
	logic [63:0]  d_q, r_q;
	logic [6:0]   cnt_q;
	logic         run_q, done_q, sat48_q;
	logic [64:0]  rt, rdiff;
	logic         ge;
	logic [63:0]  lim;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		rt    = {r_q, n_q[127]};
		rdiff = rt - {1'b0, d_q};
		ge    = rt >= {1'b0, d_q};
		lim   = sat48_q ? {16'd0, U48_MAX} : '1;
		quot  = ((|q_q[127:64]) || (q_q[63:0] > lim)) ? lim : q_q[63:0];
	end

	// advance one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			q_q     <= '0;
			d_q     <= '0;
			r_q     <= '0;
			cnt_q   <= '0;
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			sat48_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.go) begin
				n_q     <= num;
				d_q     <= den;
				r_q     <= '0;
				q_q     <= '0;
				cnt_q   <= 7'd127;
				sat48_q <= ctl.sat48;
				run_q   <= 1'b1;
			end else if (run_q) begin
				r_q   <= ge ? rdiff[63:0] : rt[63:0];
				q_q   <= {q_q[126:0], ge};
				n_q   <= {n_q[126:0], 1'b0};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

/* hdl/diagonal_lda_classifier.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// diagonal_lda_classifier: diagonal LDA classifier, top level
// Sequencer, class/feature stores and the shared multiplier and divider.
// ----------------------------------------------------------------------------
// Train squares its value in the shared multiplier; finalize runs up to a multiply
// and two divides per class and feature in use, test up to a multiply and a divide
// per class, and the prediction one compare per class.
// One request at a time: busy stays high until it ends, at its strobe if any.
// Reset and every load for class 0 start a clearing pass over
// MAX_CLASSES * 2^ceil(log2(MAX_FEATURES)) store entries (32768 by default).
// The receiver cannot stall: done marks a result for exactly one cycle.
module diagonal_lda_classifier import dlda_pkg::*; #(
	parameter int MAX_CLASSES  = MAX_CLASSES_DEF,
	parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire dlda_req_t        req,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output logic                  done,
	output dlda_res_t             res
);

	localparam int CW        = $clog2(MAX_CLASSES);
	localparam int FW        = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int AW        = CW + FW;
	localparam int SUM_DEPTH = MAX_CLASSES << FW;
	localparam int VAR_DEPTH = 1 << FW;
	localparam int NCW       = $clog2(MAX_CLASSES + 1);
	localparam int FUW       = $clog2(MAX_FEATURES + 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(SUM_DEPTH - 1);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DISP,
		S_TR_MUL,
		S_FN_WAIT, S_FN_CHK, S_FN_MUL, S_FN_CORR, S_FN_MEAN, S_FN_NEXT, S_FN_VAR,
		S_TS_WAIT, S_TS_CHK, S_TS_MUL, S_TS_DIV, S_TS_ADD, S_TS_END,
		S_AM_WAIT, S_AM_CMP
	} state_t;

	state_t state_q;

	// stores
	logic [47:0] sum_mem   [SUM_DEPTH];
	logic [63:0] sumsq_mem [SUM_DEPTH];
	logic [63:0] var_mem   [VAR_DEPTH];
	logic [15:0] size_mem  [MAX_CLASSES];
	logic [47:0] score_mem [MAX_CLASSES];

	logic [47:0] sum_rd_q, score_rd_q;
	logic [63:0] sumsq_rd_q, var_rd_q;
	logic [15:0] size_rd_q;

	// sequencer registers
	logic [CW-1:0]  c_q, best_q;
	logic [FW-1:0]  g_q;
	logic [AW-1:0]  clr_q;
	dlda_req_t      rq_q;
	logic [3:0]     class_total_q;
	logic [12:0]    feature_total_q;
	logic           finalized_q, empty_q, flat_q;
	logic [1:0]     status_q;
	logic [63:0]    pool_q, sq_q, term_q;
	logic [15:0]    n_q;
	logic [47:0]    s_q, best_score_q;
	logic [MAX_CLASSES-1:0] score_valid_q;
	logic           mul_go_q;
	logic [63:0]    op_a_q, op_b_q;
	dlda_div_ctl_t  div_ctl_q;
	logic [127:0]   num_q;
	logic [63:0]    den_q;
	logic           done_q;
	dlda_res_t      res_q;

	// shared units
	logic         mul_done, div_done;
	logic [127:0] mul_prod;
	logic [63:0]  div_quot;

	dlda_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (op_a_q),
		.b      (op_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	dlda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl_q),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// classes and features in use
	logic [NCW-1:0] nc;
	logic [FUW-1:0] fu;
	logic           last_c, last_g;

	always_comb begin
		if (class_total_q == 4'd0)
			nc = NCW'(1);
		else if (class_total_q > MAX_CLASSES)
			nc = NCW'(MAX_CLASSES);
		else
			nc = NCW'(class_total_q);
		fu = (feature_total_q > MAX_FEATURES) ? FUW'(MAX_FEATURES) : FUW'(feature_total_q);
		last_c = (NCW'(c_q) + NCW'(1)) == nc;
		last_g = (FUW'(g_q) + FUW'(1)) == fu;
	end

	// datapath arithmetic
	logic [48:0] tr_sum, ts_diff, ts_mag, mean_num, score_sum;
	logic [47:0] tr_sum_sat, ms_rd, ms_s, mean_val;
	logic [64:0] tr_sq, pool_sum;
	logic [63:0] corr_v;

	always_comb begin
		tr_sum     = {sum_rd_q[47], sum_rd_q} + {{17{rq_q.sample_value[31]}}, rq_q.sample_value};
		if (tr_sum[48] != tr_sum[47])
			tr_sum_sat = tr_sum[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		else
			tr_sum_sat = tr_sum[47:0];
		tr_sq      = {1'b0, sumsq_rd_q} + {1'b0, mul_prod[63:0]};
		ms_rd      = sum_rd_q[47] ? (48'd0 - sum_rd_q) : sum_rd_q;
		ms_s       = s_q[47] ? (48'd0 - s_q) : s_q;
		mean_num   = {1'b0, ms_s} + {34'd0, n_q[15:1]};
		mean_val   = s_q[47] ? (48'd0 - div_quot[47:0]) : div_quot[47:0];
		corr_v     = (sq_q >= div_quot) ? (sq_q - div_quot) : 64'd0;
		pool_sum   = {1'b0, pool_q} + {1'b0, corr_v};
		ts_diff    = {{17{rq_q.sample_value[31]}}, rq_q.sample_value} - {sum_rd_q[47], sum_rd_q};
		ts_mag     = ts_diff[48] ? (49'd0 - ts_diff) : ts_diff;
		score_sum  = {1'b0, score_rd_q} + {1'b0, term_q[47:0]};
	end

	// store write strobes and data
	logic            sum_we, sumsq_we, var_we, size_we, score_we;
	logic [47:0]     sum_wd;
	logic [63:0]     sumsq_wd, var_wd;
	logic [AW-1:0]   sum_addr;
	logic [FW-1:0]   var_addr;

	always_comb begin
		sum_we   = 1'b0;
		sumsq_we = 1'b0;
		var_we   = 1'b0;
		sum_wd   = '0;
		sumsq_wd = '0;
		var_wd   = '0;
		sum_addr = {c_q, g_q};
		var_addr = g_q;
		case (state_q)
			S_CLEAR: begin
				sum_we   = 1'b1;
				sumsq_we = 1'b1;
				var_we   = clr_q[AW-1:FW] == '0;
				sum_addr = clr_q;
				var_addr = clr_q[FW-1:0];
			end
			S_TR_MUL: begin
				sum_we   = mul_done;
				sumsq_we = mul_done;
				sum_wd   = tr_sum_sat;
				sumsq_wd = tr_sq[64] ? '1 : tr_sq[63:0];
			end
			S_FN_CHK: begin
				sum_we = size_rd_q == 16'd0;
			end
			S_FN_MEAN: begin
				sum_we = div_done;
				sum_wd = mean_val;
			end
			S_FN_VAR: begin
				var_we = 1'b1;
				var_wd = pool_q;
			end
			default: begin
			end
		endcase
		size_we  = (state_q == S_DISP) && (rq_q.func == FUNC_LOAD)
			&& (rq_q.class_label < MAX_CLASSES);
		score_we = state_q == S_TS_ADD;
	end

	// sum and square stores: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (sum_we)
			sum_mem[sum_addr] <= sum_wd;
		sum_rd_q <= sum_mem[sum_addr];
	end

	always_ff @(posedge clk) begin
		if (sumsq_we)
			sumsq_mem[sum_addr] <= sumsq_wd;
		sumsq_rd_q <= sumsq_mem[sum_addr];
	end

	always_ff @(posedge clk) begin
		if (var_we)
			var_mem[var_addr] <= var_wd;
		var_rd_q <= var_mem[var_addr];
	end

	always_ff @(posedge clk) begin
		if (size_we)
			size_mem[CW'(rq_q.class_label)] <= rq_q.class_size;
		size_rd_q <= size_mem[c_q];
	end

	// scores: an entry not valid reads as zero
	always_ff @(posedge clk) begin
		if (score_we)
			score_mem[c_q] <= score_sum[48] ? U48_MAX : score_sum[47:0];
		score_rd_q <= score_valid_q[c_q] ? score_mem[c_q] : 48'd0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			c_q             <= '0;
			g_q             <= '0;
			clr_q           <= '0;
			rq_q            <= '0;
			class_total_q   <= CLASS_TOTAL_RST;
			feature_total_q <= FEATURE_TOTAL_RST;
			finalized_q     <= 1'b0;
			empty_q         <= 1'b0;
			flat_q          <= 1'b0;
			status_q        <= STATUS_OK;
			pool_q          <= '0;
			sq_q            <= '0;
			term_q          <= '0;
			n_q             <= '0;
			s_q             <= '0;
			best_q          <= '0;
			best_score_q    <= '0;
			score_valid_q   <= '0;
			mul_go_q        <= 1'b0;
			op_a_q          <= '0;
			op_b_q          <= '0;
			div_ctl_q       <= '0;
			num_q           <= '0;
			den_q           <= '0;
			done_q          <= 1'b0;
			res_q           <= '0;
		end else begin
			mul_go_q     <= 1'b0;
			div_ctl_q.go <= 1'b0;
			done_q       <= 1'b0;

			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_CLASS_TOTAL:   class_total_q   <= cfg_data[3:0];
					REG_FEATURE_TOTAL: feature_total_q <= cfg_data;
					default: begin
					end
				endcase
			end

			case (state_q)
				// sweep the stores back to zero
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST)
						state_q <= S_IDLE;
				end

				S_IDLE: begin
					if (start) begin
						rq_q    <= req;
						state_q <= S_DISP;
					end
				end

				S_DISP: begin
					c_q <= CW'(rq_q.class_label);
					g_q <= FW'(rq_q.feature_index);
					case (rq_q.func)
						FUNC_LOAD: begin
							if (rq_q.class_label == 3'd0) begin
								finalized_q   <= 1'b0;
								status_q      <= STATUS_OK;
								score_valid_q <= '0;
								clr_q         <= '0;
								state_q       <= S_CLEAR;
							end else begin
								state_q <= S_IDLE;
							end
						end
						FUNC_TRAIN: begin
							if (finalized_q || (rq_q.class_label >= nc)
								|| (rq_q.feature_index >= fu)) begin
								state_q <= S_IDLE;
							end else begin
								op_a_q   <= {32'd0, rq_q.sample_value[31]
									? (32'd0 - rq_q.sample_value) : rq_q.sample_value};
								op_b_q   <= {32'd0, rq_q.sample_value[31]
									? (32'd0 - rq_q.sample_value) : rq_q.sample_value};
								mul_go_q <= 1'b1;
								state_q  <= S_TR_MUL;
							end
						end
						FUNC_FINALIZE: begin
							if (finalized_q) begin
								done_q  <= 1'b1;
								res_q   <= '{result_kind: KIND_STATUS, best_class: 3'd0,
									status: status_q};
								state_q <= S_IDLE;
							end else if (fu == '0) begin
								finalized_q <= 1'b1;
								status_q    <= STATUS_OK;
								done_q      <= 1'b1;
								res_q       <= '{result_kind: KIND_STATUS,
									best_class: 3'd0, status: STATUS_OK};
								state_q     <= S_IDLE;
							end else begin
								c_q     <= '0;
								g_q     <= '0;
								pool_q  <= '0;
								empty_q <= 1'b0;
								flat_q  <= 1'b0;
								state_q <= S_FN_WAIT;
							end
						end
						default: begin
							c_q <= '0;
							if (rq_q.feature_index < fu)
								state_q <= S_TS_WAIT;
							else
								state_q <= S_TS_END;
						end
					endcase
				end

				// hold until the square is ready; stores are written meanwhile
				S_TR_MUL: begin
					if (mul_done)
						state_q <= S_IDLE;
				end

				S_FN_WAIT: state_q <= S_FN_CHK;

				S_FN_CHK: begin
					n_q  <= size_rd_q;
					s_q  <= sum_rd_q;
					sq_q <= sumsq_rd_q;
					if (size_rd_q == 16'd0) begin
						empty_q <= 1'b1;
						state_q <= S_FN_NEXT;
					end else begin
						op_a_q   <= {16'd0, ms_rd};
						op_b_q   <= {16'd0, ms_rd};
						mul_go_q <= 1'b1;
						state_q  <= S_FN_MUL;
					end
				end

				// correction term: floor(sum^2 / size)
				S_FN_MUL: begin
					if (mul_done) begin
						num_q           <= mul_prod;
						den_q           <= {48'd0, n_q};
						div_ctl_q.go    <= 1'b1;
						div_ctl_q.sat48 <= 1'b0;
						state_q         <= S_FN_CORR;
					end
				end

				// pool the class variance, then round the mean
				S_FN_CORR: begin
					if (div_done) begin
						pool_q          <= pool_sum[64] ? '1 : pool_sum[63:0];
						num_q           <= {79'd0, mean_num};
						den_q           <= {48'd0, n_q};
						div_ctl_q.go    <= 1'b1;
						div_ctl_q.sat48 <= 1'b0;
						state_q         <= S_FN_MEAN;
					end
				end

				S_FN_MEAN: begin
					if (div_done)
						state_q <= S_FN_NEXT;
				end

				S_FN_NEXT: begin
					if (last_c) begin
						state_q <= S_FN_VAR;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_FN_WAIT;
					end
				end

				// store the pooled variance and advance the feature
				S_FN_VAR: begin
					if (last_g) begin
						finalized_q <= 1'b1;
						if (empty_q)
							status_q <= STATUS_EMPTY;
						else if (flat_q || (pool_q == '0))
							status_q <= STATUS_FLAT;
						else
							status_q <= STATUS_OK;
						done_q <= 1'b1;
						res_q  <= '{result_kind: KIND_STATUS, best_class: 3'd0,
							status: empty_q ? STATUS_EMPTY
								: ((flat_q || (pool_q == '0)) ? STATUS_FLAT : STATUS_OK)};
						state_q <= S_IDLE;
					end else begin
						if (pool_q == '0)
							flat_q <= 1'b1;
						g_q     <= g_q + FW'(1);
						c_q     <= '0;
						pool_q  <= '0;
						state_q <= S_FN_WAIT;
					end
				end

				S_TS_WAIT: state_q <= S_TS_CHK;

				S_TS_CHK: begin
					if (var_rd_q == '0) begin
						term_q  <= {16'd0, U48_MAX};
						state_q <= S_TS_ADD;
					end else begin
						op_a_q   <= {15'd0, ts_mag};
						op_b_q   <= {15'd0, ts_mag};
						mul_go_q <= 1'b1;
						state_q  <= S_TS_MUL;
					end
				end

				// term: floor(d^2 * 2^16 / var)
				S_TS_MUL: begin
					if (mul_done) begin
						num_q           <= {mul_prod[111:0], 16'd0};
						den_q           <= var_rd_q;
						div_ctl_q.go    <= 1'b1;
						div_ctl_q.sat48 <= 1'b1;
						state_q         <= S_TS_DIV;
					end
				end

				S_TS_DIV: begin
					if (div_done) begin
						term_q  <= div_quot;
						state_q <= S_TS_ADD;
					end
				end

				S_TS_ADD: begin
					score_valid_q[c_q] <= 1'b1;
					if (last_c) begin
						state_q <= S_TS_END;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_TS_WAIT;
					end
				end

				S_TS_END: begin
					if (rq_q.last_feature) begin
						c_q     <= '0;
						state_q <= S_AM_WAIT;
					end else begin
						state_q <= S_IDLE;
					end
				end

				S_AM_WAIT: state_q <= S_AM_CMP;

				// keep the lowest score; a tie stays with the lower class
				S_AM_CMP: begin
					if ((c_q == '0) || (score_rd_q < best_score_q)) begin
						best_q       <= c_q;
						best_score_q <= score_rd_q;
					end
					if (last_c) begin
						score_valid_q <= '0;
						done_q        <= 1'b1;
						res_q         <= '{result_kind: KIND_PREDICT,
							best_class: ((c_q == '0) || (score_rd_q < best_score_q))
								? 3'(c_q) : 3'(best_q),
							status: STATUS_OK};
						state_q       <= S_IDLE;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_AM_WAIT;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

/* verif/diagonal_lda_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_lda_checker: scoreboard for the diagonal LDA classifier
// Mirrors the class stores, sums, pooled variances and scores, predicts the
// status and prediction results of each accepted request and compares them
// field by field with the result strobes.
// ----------------------------------------------------------------------------
module diagonal_lda_checker import dlda_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire dlda_req_t        req,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             done,
	input  wire dlda_res_t        res,
	output int                    fail_count,
	output int                    pending,
	output int                    result_count
);

	localparam int NCLS = MAX_CLASSES_DEF;
	localparam int NFEAT = MAX_FEATURES_DEF;
	localparam logic signed [63:0] SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_LO = -64'sh0000_8000_0000_0000;

	logic [15:0]        size_mem [NCLS];
	logic signed [47:0] mean_sum [NCLS*NFEAT];
	logic [63:0]        sq_sum [NCLS*NFEAT];
	logic [63:0]        pool_var [NFEAT];
	logic [47:0]        score [NCLS];
	bit                 trained_done;
	logic [1:0]         held_status;
	logic [3:0]         class_total;
	logic [12:0]        feature_total;
	dlda_res_t          expected_q [$];

	function automatic int classes_used();
		if (class_total == 0) return 1;
		return (class_total > NCLS) ? NCLS : int'(class_total);
	endfunction

	function automatic int features_used();
		return (feature_total > NFEAT) ? NFEAT : int'(feature_total);
	endfunction

	function automatic logic [63:0] mag(logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] div_sat(logic [127:0] num, logic [63:0] den,
		logic [63:0] lim);
		logic [127:0] q;
		q = num / {64'd0, den};
		return (q > {64'd0, lim}) ? lim : q[63:0];
	endfunction

	// wipe everything a new training run starts from
	task automatic clear_training();
		for (int i = 0; i < NCLS*NFEAT; i++) begin
			mean_sum[i] = '0;
			sq_sum[i] = '0;
		end
		for (int i = 0; i < NFEAT; i++) pool_var[i] = '0;
		for (int i = 0; i < NCLS; i++) score[i] = '0;
		trained_done = 0;
		held_status = STATUS_OK;
	endtask

	// turn sums into means and pool the variance per feature
	function automatic logic [1:0] finalize_stores();
		bit empty, flat;
		int at;
		logic [63:0] n, ms, corr, v, pool;
		logic [64:0] acc;
		empty = 0;
		flat = 0;
		for (int g = 0; g < features_used(); g++) begin
			pool = '0;
			for (int c = 0; c < classes_used(); c++) begin
				at = c*NFEAT + g;
				n = 64'(size_mem[c]);
				if (n == 0) begin
					empty = 1;
					mean_sum[at] = '0;
					continue;
				end
				ms = mag(64'(mean_sum[at]));
				corr = div_sat({64'd0, ms} * {64'd0, ms}, n, '1);
				v = (sq_sum[at] >= corr) ? sq_sum[at] - corr : '0;
				acc = {1'b0, pool} + {1'b0, v};
				pool = acc[64] ? '1 : acc[63:0];
				ms = (ms + n/2) / n;
				mean_sum[at] = mean_sum[at][47] ? 48'(-ms) : 48'(ms);
			end
			pool_var[g] = pool;
			if (pool == 0) flat = 1;
		end
		return empty ? STATUS_EMPTY : (flat ? STATUS_FLAT : STATUS_OK);
	endfunction

	// apply one request and queue the result it causes, if any
	task automatic predict_request(dlda_req_t r);
		dlda_res_t e;
		logic signed [63:0] x, s;
		logic [63:0] sq, d, vr;
		logic [64:0] acc;
		logic [127:0] p;
		logic [47:0] term;
		logic [48:0] sc;
		int at, best;
		x = 64'(r.sample_value);
		case (r.func)
			FUNC_LOAD: begin
				if (r.class_label == 0) clear_training();
				size_mem[r.class_label] = r.class_size;
			end
			FUNC_TRAIN: begin
				if (!trained_done && r.class_label < classes_used() &&
						r.feature_index < features_used()) begin
					at = r.class_label*NFEAT + r.feature_index;
					s = 64'(mean_sum[at]) + x;
					mean_sum[at] = (s > SUM_HI) ? 48'(SUM_HI) :
						((s < SUM_LO) ? 48'(SUM_LO) : 48'(s));
					sq = mag(x) * mag(x);
					acc = {1'b0, sq_sum[at]} + {1'b0, sq};
					sq_sum[at] = acc[64] ? '1 : acc[63:0];
				end
			end
			FUNC_FINALIZE: begin
				if (!trained_done) begin
					held_status = finalize_stores();
					trained_done = 1;
				end
				e.result_kind = KIND_STATUS;
				e.best_class = '0;
				e.status = held_status;
				expected_q.push_back(e);
			end
			default: begin
				if (r.feature_index < features_used()) begin
					vr = pool_var[r.feature_index];
					for (int c = 0; c < classes_used(); c++) begin
						term = U48_MAX;
						if (vr != 0) begin
							d = mag(x - 64'(mean_sum[c*NFEAT + r.feature_index]));
							p = ({64'd0, d} * {64'd0, d}) << 16;
							term = 48'(div_sat(p, vr, {16'd0, U48_MAX}));
						end
						sc = {1'b0, score[c]} + {1'b0, term};
						score[c] = sc[48] ? U48_MAX : sc[47:0];
					end
				end
				if (r.last_feature) begin
					best = 0;
					for (int c = 1; c < classes_used(); c++)
						if (score[c] < score[best]) best = c;
					for (int c = 0; c < NCLS; c++) score[c] = '0;
					e.result_kind = KIND_PREDICT;
					e.best_class = 3'(best);
					e.status = STATUS_OK;
					expected_q.push_back(e);
				end
			end
		endcase
	endtask

	// compare one strobed result with the oldest expectation
	task automatic check_result(dlda_res_t a);
		dlda_res_t e;
		result_count++;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result kind=%0d class=%0d status=%0d",
				$time, a.result_kind, a.best_class, a.status);
			fail_count++;
			return;
		end
		e = expected_q.pop_front();
		if (a.result_kind !== e.result_kind) begin
			$display("%0t: result_kind expected %0d got %0d", $time,
				e.result_kind, a.result_kind);
			fail_count++;
		end
		if (a.best_class !== e.best_class) begin
			$display("%0t: best_class expected %0d got %0d", $time,
				e.best_class, a.best_class);
			fail_count++;
		end
		if (a.status !== e.status) begin
			$display("%0t: status expected %0d got %0d", $time, e.status, a.status);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
		pending = 0;
	end

	// watch the channels: results first, then new writes and requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCLS; i++) size_mem[i] = '0;
			clear_training();
			class_total = CLASS_TOTAL_RST;
			feature_total = FEATURE_TOTAL_RST;
			expected_q.delete();
		end else begin
			if (done) check_result(res);
			if (cfg_we) begin
				if (cfg_index == REG_CLASS_TOTAL) class_total = cfg_data[3:0];
				else feature_total = cfg_data;
			end
			if (start && !busy) predict_request(req);
		end
		pending = expected_q.size();
	end

endmodule

/* verif/diagonal_lda_classifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_lda_classifier_tb: testbench top of the diagonal LDA classifier
// Runs training sessions under several class and feature settings: loads,
// training values, finalize and test subjects, plus noise, with random gaps.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module diagonal_lda_classifier_tb;
	import dlda_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int PHASES = 8;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	dlda_req_t        req;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             done;
	dlda_res_t        res;
	int               fail_count;
	int               pending;
	int               result_count;
	int               cycles;
	int               request_count;

	// class and feature settings per session, and a wide feature setting for
	// the tests after finalize (0 keeps the training setting)
	int class_set [PHASES] = '{2, 8, 0, 15, 3, 5, 8, 1};
	int feat_set  [PHASES] = '{2, 1, 3, 4, 1, 2, 4, 3};
	int wide_set  [PHASES] = '{4096, 0, 8191, 0, 0, 4096, 0, 0};

	diagonal_lda_classifier u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .res(res)
	);

	diagonal_lda_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .res(res), .fail_count(fail_count), .pending(pending),
		.result_count(result_count)
	);

	initial clk = 0;
	always #1 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// value around a class-dependent centre, now and then fully random
	function automatic logic [31:0] pick_value(int cls);
		if ($urandom_range(0, 9) == 0) return $urandom;
		return 32'((cls*3 - 8) * 65536 + int'($urandom_range(0, 32'h3FFFF)) - 32'h20000);
	endfunction

	// hold the request until the block takes it, then idle at random
	task automatic send(dlda_req_t r);
		int g;
		start = 1;
		req = r;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		request_count++;
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			start = 0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic send_item(logic [1:0] f, int cls, int feat, logic [31:0] v,
		logic [15:0] sz, logic lst);
		dlda_req_t r;
		r.func = f;
		r.class_label = 3'(cls);
		r.feature_index = 12'(feat);
		r.sample_value = v;
		r.class_size = sz;
		r.last_feature = lst;
		send(r);
	endtask

	// wait for every result and for the block to go quiet
	task automatic wait_idle();
		start = 0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (20) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = CFG_W'(val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// one training session with finalize and test subjects
	task automatic run_session(int p);
		int nc, nf, lbl, sz;
		nc = (class_set[p] == 0) ? 1 : ((class_set[p] > 8) ? 8 : class_set[p]);
		nf = feat_set[p];
		wait_idle();
		write_reg(REG_CLASS_TOTAL, class_set[p]);
		write_reg(REG_FEATURE_TOTAL, nf);
		// load every class size; class 0 first starts the new training
		for (int c = 0; c < 8; c++) begin
			sz = $urandom_range(1, 20);
			if ($urandom_range(0, 19) == 0) sz = 0;
			if (p == 0 && c == 0) sz = 65535;
			if (p == 4 && c == 2) sz = 0;
			send_item(FUNC_LOAD, c, $urandom_range(0, 4095), $urandom, 16'(sz),
				1'($urandom));
		end
		if (p == 0) begin
			// extremes, ignored labels and features, test before finalize
			send_item(FUNC_TRAIN, 0, 0, 32'h7FFF_FFFF, 16'hFFFF, 1);
			send_item(FUNC_TRAIN, 1, 1, 32'h8000_0000, 16'h0000, 0);
			send_item(FUNC_TRAIN, 1, 0, 32'h0000_0000, 16'h0000, 0);
			send_item(FUNC_TRAIN, 5, 0, 32'h0001_0000, 16'h0000, 0);
			send_item(FUNC_TRAIN, 0, 3, 32'h0001_0000, 16'h0000, 0);
			send_item(FUNC_TRAIN, 7, 4095, 32'hFFFF_FFFF, 16'h0000, 1);
			send_item(FUNC_TEST, 0, 0, 32'h0000_1000, 16'h0000, 0);
			send_item(FUNC_TEST, 7, 4095, 32'h0000_1000, 16'hFFFF, 1);
		end
		// training values, mostly in use, some out of range
		for (int i = 0; i < 30; i++) begin
			lbl = ($urandom_range(0, 9) < 8) ? $urandom_range(0, nc - 1) : $urandom_range(0, 7);
			send_item(FUNC_TRAIN, lbl,
				($urandom_range(0, 9) < 9) ? $urandom_range(0, nf - 1) : $urandom_range(0, 4095),
				pick_value(lbl), 16'($urandom), 1'($urandom));
		end
		if ($urandom_range(0, 1) == 1)
			send_item(FUNC_TEST, 0, 0, pick_value(0), 16'($urandom), 1);
		send_item(FUNC_FINALIZE, $urandom_range(0, 7), $urandom_range(0, 4095), $urandom,
			16'($urandom), 1'($urandom));
		// repeated finalize and train after finalize, both without effect
		send_item(FUNC_FINALIZE, 0, 0, 0, 0, 0);
		send_item(FUNC_TRAIN, 0, 0, pick_value(0), 0, 0);
		// test subjects: one value per feature, last one marked
		for (int s = 0; s < 8; s++) begin
			lbl = $urandom_range(0, nc - 1);
			for (int g = 0; g < nf; g++)
				send_item(FUNC_TEST, $urandom_range(0, 7), g, pick_value(lbl),
					16'($urandom), 1'(g == nf - 1));
			if ($urandom_range(0, 3) == 0)
				send_item(FUNC_TEST, 0, $urandom_range(0, 4095), $urandom, 16'($urandom),
					1'($urandom));
		end
		// wide feature setting: tests over the whole index range
		if (wide_set[p] != 0) begin
			wait_idle();
			write_reg(REG_FEATURE_TOTAL, wide_set[p]);
			for (int i = 0; i < 12; i++)
				send_item(FUNC_TEST, $urandom_range(0, 7), $urandom_range(0, 4095), $urandom,
					16'($urandom), 1'($urandom_range(0, 2) == 0));
			send_item(FUNC_TEST, 0, 4095, 32'h0, 0, 1);
		end
	endtask

	initial begin
		cycles = 0;
		request_count = 0;
		arst_n = 0;
		start = 0;
		req = '0;
		cfg_we = 0;
		cfg_index = REG_CLASS_TOTAL;
		cfg_data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (int p = 0; p < PHASES; p++) run_session(p);
		wait_idle();
		repeat (300) @(negedge clk);
		$display("Ran %0d requests over %0d training sessions, %0d results checked.",
			request_count, PHASES, result_count);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
